[sv/lbs_pkg.sv]
// Shared types, codes and helper functions for the skinning engine.
`timescale 1ns / 1ps
`default_nettype none
package lbs_pkg;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_POSE = 2'd1;
  localparam logic [1:0] MODE_BIND = 2'd2;

  localparam int WORDS_PER_JOINT = 12;
  localparam logic [3:0] WORD_CNT = 4'd12;
  localparam int ADDR_FULL_W = 10;
  localparam int DIV_STEPS = 2;
  localparam logic [33:0] DIV_BIAS = 34'd4194304000;
  localparam logic signed [29:0] QUO_BIAS = 30'sd4194304;
  localparam logic [30:0] RECIP_125 = 31'd1099511628;

  typedef struct packed {
    logic [1:0]         mode;
    logic [4:0]         joint_sel;
    logic [3:0]         word_sel;
    logic signed [15:0] word_value;
    logic [15:0]        blend_weight;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [23:0] coord_z;
    logic               last_binding;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic               result_kind;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_PMAC, S_DLOAD, S_DIV, S_BMAC, S_WEIGHT, S_ACC, S_EMIT
  } lbs_state_t;

  typedef struct packed {
    logic       take;
    logic       mac_clr;
    logic [3:0] rd_idx;
    logic       cap;
    logic [3:0] cap_idx;
    logic       mac;
    logic [1:0] k;
    logic       div_load;
    logic       div_step;
    logic       weight;
    logic       acc_upd;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic bind_full;
    logic out_busy;
    logic pose;
    logic last;
  } dp_stat_t;

  function automatic logic [ADDR_FULL_W-1:0] word_addr(input logic [4:0] joint,
                                                       input logic [3:0] word);
    logic [ADDR_FULL_W-1:0] j;
    j = ADDR_FULL_W'(joint);
    return (j << 3) + (j << 2) + ADDR_FULL_W'(word);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sh0000_7fff_ffff) return 32'sh7fff_ffff;
    if (v < -48'sh0000_8000_0000) return -32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'sh0000_007f_ffff) return 24'sh7f_ffff;
    if (v < -48'sh0000_0080_0000) return -24'sh80_0000;
    return v[23:0];
  endfunction

endpackage
`default_nettype wire

[sv/lbs_datapath.sv]
// Datapath: pose memory, three arithmetic lanes, divider by 1000, accumulators, output register.
`timescale 1ns / 1ps
`default_nettype none
module lbs_datapath #(
  parameter int JOINT_COUNT = 24,
  parameter int MAX_BINDS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  lbs_pkg::in_item_t in_data,
  input  lbs_pkg::dp_cmd_t  cmd,
  output lbs_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output lbs_pkg::out_item_t out_data
);
  import lbs_pkg::*;

  localparam int DEPTH = JOINT_COUNT * WORDS_PER_JOINT;
  localparam int AW = $clog2(DEPTH);
  localparam int BW = $clog2(MAX_BINDS + 1);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata;
  in_item_t item;
  logic signed [15:0] pos [3];
  logic signed [15:0] rot [9];
  logic signed [43:0] mac [3];
  logic [29:0] dv [3];
  logic [23:0] dquo [3];
  logic signed [29:0] qs [3];
  logic signed [46:0] prod [3];
  logic signed [31:0] acc [3];
  logic [BW-1:0] bind_count;

  logic wr_ok, joint_ok;
  logic [ADDR_FULL_W-1:0] wr_full, rd_full;
  logic [AW-1:0] wr_a, rd_a;
  logic signed [23:0] cv [3];
  logic signed [25:0] dvec [3];
  logic signed [15:0] ma [3];
  logic signed [25:0] mb [3];
  logic signed [44:0] x45 [3];
  logic signed [29:0] dq [3];
  logic [23:0] fr1000 [3];
  logic signed [16:0] smm [3];
  logic signed [33:0] smm_sh [3];
  logic signed [33:0] num [3];
  logic [33:0] ub [3];
  logic [60:0] rprod [3];
  logic signed [16:0] wt;

  assign wr_ok = cmd.take && (in_data.mode == MODE_LOAD) &&
                 (32'(in_data.joint_sel) < JOINT_COUNT) && (in_data.word_sel < WORD_CNT);
  assign wr_full = word_addr(in_data.joint_sel, in_data.word_sel);
  assign wr_a = wr_full[AW-1:0];
  assign joint_ok = 32'(item.joint_sel) < JOINT_COUNT;
  assign rd_full = word_addr(item.joint_sel, cmd.rd_idx);
  assign rd_a = (joint_ok && cmd.rd_idx < WORD_CNT) ? rd_full[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_a] <= in_data.word_value;
    end
    rdata <= mem[rd_a];
  end

  assign cv[0] = item.coord_x;
  assign cv[1] = item.coord_y;
  assign cv[2] = item.coord_z;
  assign wt = signed'({1'b0, item.blend_weight});

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dvec[l] = signed'({{2{cv[l][23]}}, cv[l]} - qs[l][25:0]);
    end
    for (int l = 0; l < 3; l++) begin
      ma[l] = '0;
      mb[l] = '0;
      for (int kk = 0; kk < 3; kk++) begin
        if (cmd.k == 2'(kk)) begin
          if (item.mode == MODE_POSE) begin
            ma[l] = rot[3*l+kk];
            mb[l] = 26'(cv[kk]);
          end else begin
            ma[l] = rot[3*kk+l];
            mb[l] = dvec[kk];
          end
        end
      end
      smm[l] = (l == 1) ? -17'(pos[l]) : 17'(pos[l]);
      smm_sh[l] = 34'(smm[l]) <<< 16;
      x45[l] = 45'(mac[l]) + 45'sd8192;
      dq[l] = signed'(x45[l][43:14]);
      fr1000[l] = (24'(x45[l][13:0]) << 10) - (24'(x45[l][13:0]) << 5) +
                  (24'(x45[l][13:0]) << 3);
      if (item.mode == MODE_POSE) begin
        num[l] = smm_sh[l] + 34'(fr1000[l][23:14]);
      end else begin
        num[l] = smm_sh[l] + 34'sd500;
      end
      ub[l] = 34'(num[l]) + DIV_BIAS;
      rprod[l] = dv[l] * RECIP_125;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item <= in_data;
    end
    if (cmd.cap) begin
      if (cmd.cap_idx < 4'd3) begin
        pos[cmd.cap_idx[1:0]] <= joint_ok ? rdata : '0;
      end else if (cmd.cap_idx < WORD_CNT) begin
        rot[cmd.cap_idx - 4'd3] <= joint_ok ? rdata : '0;
      end
    end
    for (int l = 0; l < 3; l++) begin
      if (cmd.mac_clr) begin
        mac[l] <= '0;
      end else if (cmd.mac) begin
        mac[l] <= mac[l] + (44'(ma[l]) * 44'(mb[l]));
      end
      if (cmd.div_load) begin
        dv[l] <= ub[l][32:3];
      end
      if (cmd.div_step) begin
        dquo[l] <= rprod[l][60:37];
        qs[l] <= 30'(signed'({1'b0, dquo[l]})) - QUO_BIAS +
                 ((item.mode == MODE_POSE) ? dq[l] : 30'sd0);
      end
      if (cmd.weight) begin
        prod[l] <= qs[l] * wt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < 3; l++) acc[l] <= '0;
      bind_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.acc_upd) begin
        for (int l = 0; l < 3; l++) begin
          acc[l] <= sat32(48'(acc[l]) + ((48'(prod[l]) + 48'sd16384) >>> 15));
        end
        bind_count <= bind_count + 1'b1;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (item.mode == MODE_POSE) begin
          out_data.out_x <= sat24(48'(acc[0]));
          out_data.out_y <= sat24(48'(acc[1]));
          out_data.out_z <= sat24(48'(acc[2]));
          out_data.result_kind <= 1'b0;
          for (int l = 0; l < 3; l++) acc[l] <= '0;
          bind_count <= '0;
        end else begin
          out_data.out_x <= sat24((48'(mac[0]) + 48'sd8192) >>> 14);
          out_data.out_y <= sat24((48'(mac[1]) + 48'sd8192) >>> 14);
          out_data.out_z <= sat24((48'(mac[2]) + 48'sd8192) >>> 14);
          out_data.result_kind <= 1'b1;
        end
      end
    end
  end

  assign stat.bind_full = bind_count >= BW'(MAX_BINDS);
  assign stat.out_busy = out_valid && !out_ready;
  assign stat.pose = item.mode == MODE_POSE;
  assign stat.last = item.last_binding;

endmodule
`default_nettype wire

[sv/lbs_controller.sv]
// Controller state machine that sequences memory reads, MAC steps, division and output.
`timescale 1ns / 1ps
`default_nettype none
module lbs_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic              in_last,
  input  lbs_pkg::dp_stat_t stat,
  output lbs_pkg::dp_cmd_t  cmd
);
  import lbs_pkg::*;

  localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);

  lbs_state_t state, state_next;
  logic [5:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt + 6'd1;
    cmd = '0;
    cmd.rd_idx = cnt[3:0];
    cmd.cap_idx = cnt[3:0] - 4'd1;
    cmd.k = cnt[1:0];
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cnt_next = '0;
        if (in_valid) begin
          cmd.take = 1'b1;
          cmd.mac_clr = 1'b1;
          case (in_mode)
            MODE_POSE: begin
              if (!stat.bind_full) state_next = S_READ;
              else if (in_last) state_next = S_EMIT;
            end
            MODE_BIND: state_next = S_READ;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        cmd.cap = cnt != 6'd0;
        if (cnt == 6'd12) begin
          cnt_next = '0;
          state_next = stat.pose ? S_PMAC : S_DLOAD;
        end
      end
      S_PMAC: begin
        cmd.mac = 1'b1;
        if (cnt == 6'd2) state_next = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        cmd.mac_clr = !stat.pose;
        cnt_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) begin
          cnt_next = '0;
          state_next = stat.pose ? S_WEIGHT : S_BMAC;
        end
      end
      S_BMAC: begin
        cmd.mac = 1'b1;
        if (cnt == 6'd2) state_next = S_EMIT;
      end
      S_WEIGHT: begin
        cmd.weight = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_upd = 1'b1;
        state_next = stat.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[sv/linear_blend_skinning_core.sv]
// Top level of the linear blend skinning engine.
// Input channel in_valid/in_ready/in_data carries one item per transfer; output channel
// out_valid/out_ready/out_data carries at most one result per item.
// A pose load (mode 0) is written and the next item can follow at once.
// In a pose binding and a bind item, twelve pose words are read one per cycle from the
// pose memory, and each axis is divided by 1000 through a registered reciprocal
// multiply, with the three axes in parallel; the dot products come before the division
// in a pose binding and after it in a bind item.
// A bind result enters the output register from the emit state after its dot products;
// a posed point does so after the accumulation step of its last binding.
// A binding past the per-point limit is dropped; if it is last, the point is emitted.
// The result sits in an output register; while the receiver stalls, the block keeps
// working on the next item and only waits when it has a new result to present.
// Reset clears the accumulators, the binding count and the output valid flag; the
// pose memory holds garbage until it is loaded.
`timescale 1ns / 1ps
`default_nettype none
module linear_blend_skinning_core #(
  parameter int JOINT_COUNT = 24,
  parameter int MAX_BINDS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lbs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lbs_pkg::out_item_t out_data
);
  import lbs_pkg::*;

  dp_cmd_t cmd;
  dp_stat_t stat;

  lbs_controller u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_data.mode),
    .in_last(in_data.last_binding),
    .stat(stat),
    .cmd(cmd)
  );

  lbs_datapath #(
    .JOINT_COUNT(JOINT_COUNT),
    .MAX_BINDS(MAX_BINDS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .in_data(in_data),
    .cmd(cmd),
    .stat(stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule
`default_nettype wire

[sv/lbs_checker.sv]
// Port-level checker for the skinning engine and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module lbs_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire lbs_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire lbs_pkg::out_item_t out_data
);
  import lbs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Output transfer dropped or changed while stalled.");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("Output valid after reset.");

  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.mode == MODE_LOAD |=> in_ready)
    else $error("Pose load did not complete in one cycle.");

  a_bind_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.mode == MODE_BIND |=> !$rose(out_valid))
    else $error("Bind result appeared too early.");

endmodule

bind linear_blend_skinning_core lbs_checker u_lbs_checker (.*);
`default_nettype wire

[tb/linear_blend_skinning_core_tb.sv]
// Self-checking testbench for the linear blend skinning core: pose loads, bindings, bind points.
`timescale 1ns / 1ps
module linear_blend_skinning_core_tb;
  import lbs_pkg::*;

  localparam int JOINTS = 24;
  localparam int BIND_LIMIT = 4;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  logic [15:0] pose_words [0:JOINTS*WORDS_PER_JOINT-1];
  longint pos_acc [0:2];
  int bindings_taken = 0;
  out_item_t expected_points [$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  linear_blend_skinning_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic longint floor_quot(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint round_quot(longint n, longint d);
    return floor_quot(n + d / 2, d);
  endfunction

  function automatic longint clamp_bits(longint v, int bits);
    longint lim;
    lim = longint'(1) << (bits - 1);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint joint_word(int j, int k);
    if (j >= JOINTS) return 0;
    return longint'($signed(pose_words[j*WORDS_PER_JOINT+k]));
  endfunction

  task automatic skin_item(input in_item_t it, output bit emits, output out_item_t r);
    longint c [0:2];
    longint d [0:2];
    longint res [0:2];
    longint dot, num, term, contrib, s, sgn, wgt;
    int j;
    emits = 1'b0;
    r = '0;
    c[0] = longint'(it.coord_x);
    c[1] = longint'(it.coord_y);
    c[2] = longint'(it.coord_z);
    j = int'(it.joint_sel);
    wgt = longint'(it.blend_weight);
    case (it.mode)
      MODE_LOAD: begin
        if (j < JOINTS && it.word_sel < WORD_CNT)
          pose_words[j*WORDS_PER_JOINT+int'(it.word_sel)] = it.word_value;
      end
      MODE_POSE: begin
        if (bindings_taken < BIND_LIMIT) begin
          for (int i = 0; i < 3; i++) begin
            dot = 0;
            for (int k = 0; k < 3; k++) dot += joint_word(j, 3 + 3*i + k) * c[k];
            sgn = (i == 1) ? -1 : 1;
            num = sgn * joint_word(j, i) * (longint'(1) << 30) + 1000 * dot;
            term = round_quot(num, 1000 * 16384);
            contrib = round_quot(term * wgt, 32768);
            pos_acc[i] = clamp_bits(pos_acc[i] + contrib, 32);
          end
          bindings_taken++;
        end
        if (it.last_binding) begin
          emits = 1'b1;
          r.out_x = 24'(clamp_bits(pos_acc[0], 24));
          r.out_y = 24'(clamp_bits(pos_acc[1], 24));
          r.out_z = 24'(clamp_bits(pos_acc[2], 24));
          r.result_kind = 1'b0;
          for (int i = 0; i < 3; i++) pos_acc[i] = 0;
          bindings_taken = 0;
        end
      end
      MODE_BIND: begin
        for (int i = 0; i < 3; i++) begin
          sgn = (i == 1) ? -1 : 1;
          d[i] = c[i] - round_quot(sgn * joint_word(j, i) * 65536, 1000);
        end
        for (int k = 0; k < 3; k++) begin
          s = 0;
          for (int i = 0; i < 3; i++) s += joint_word(j, 3 + 3*i + k) * d[i];
          res[k] = clamp_bits(round_quot(s, 16384), 24);
        end
        emits = 1'b1;
        r.out_x = 24'(res[0]);
        r.out_y = 24'(res[1]);
        r.out_z = 24'(res[2]);
        r.result_kind = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input in_item_t it);
    bit emits;
    out_item_t r;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    skin_item(it, emits, r);
    if (emits) expected_points = {expected_points, r};
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        exp_r = expected_points.pop_front();
        if (out_data.out_x !== exp_r.out_x || out_data.out_y !== exp_r.out_y ||
            out_data.out_z !== exp_r.out_z || out_data.result_kind !== exp_r.result_kind) begin
          $display("%0t: mismatch, expected x=%0d y=%0d z=%0d kind=%0d,", $time,
                   exp_r.out_x, exp_r.out_y, exp_r.out_z, exp_r.result_kind,
                   " actual x=%0d y=%0d z=%0d kind=%0d",
                   out_data.out_x, out_data.out_y, out_data.out_z, out_data.result_kind);
          errors++;
        end
      end
    end
  end

  function automatic in_item_t make_item(logic [1:0] mode, int j, longint x, longint y,
                                         longint z, int wgt, bit last);
    in_item_t it;
    it = '0;
    it.mode = mode;
    it.joint_sel = 5'(j);
    it.coord_x = 24'(x);
    it.coord_y = 24'(y);
    it.coord_z = 24'(z);
    it.blend_weight = 16'(wgt);
    it.last_binding = last;
    return it;
  endfunction

  function automatic in_item_t load_item(int j, int w, int v);
    in_item_t it;
    it = '0;
    it.mode = MODE_LOAD;
    it.joint_sel = 5'(j);
    it.word_sel = 4'(w);
    it.word_value = 16'(v);
    return it;
  endfunction

  function automatic longint rand_coord();
    if ($urandom_range(3) == 0) return longint'($signed(24'($urandom)));
    return longint'($urandom_range(262144)) - 131072;
  endfunction

  // Every joint is written before any use so that no unwritten word is ever read.
  task automatic test_table_load();
    int v;
    for (int j = 0; j < JOINTS; j++)
      for (int w = 0; w < WORDS_PER_JOINT; w++) begin
        if (j == 0) v = (w < 3) ? 0 : ((w == 3 || w == 7 || w == 11) ? 16384 : 0);
        else if (j == 1) v = -32768;
        else if (j == 2) v = 32767;
        else v = $urandom_range(65535);
        send_item(load_item(j, w, v));
      end
  endtask

  task automatic test_directed();
    send_item(make_item(MODE_BIND, 0, 8388607, -8388608, 65536, 0, 0));
    send_item(make_item(MODE_BIND, 1, -8388608, -8388608, -8388608, 0, 0));
    send_item(make_item(MODE_BIND, 2, 8388607, 8388607, 8388607, 0, 0));
    send_item(make_item(MODE_BIND, 30, 12345, -777, 1, 0, 0));
    send_item(make_item(MODE_POSE, 1, -8388608, -8388608, -8388608, 65535, 1));
    send_item(make_item(MODE_POSE, 0, 65536, 131072, -65536, 32768, 1));
    for (int i = 0; i < 6; i++)
      send_item(make_item(MODE_POSE, 2, 8388607, 8388607, 8388607, 32768, i == 5));
    send_item(make_item(MODE_POSE, 31, 1000, 2000, 3000, 40000, 0));
    send_item(make_item(MODE_POSE, 0, 1000, 2000, 3000, 16384, 1));
    send_item(load_item(24, 0, 1234));
    send_item(load_item(3, 12, -5));
    send_item(load_item(31, 15, 32767));
    send_item(make_item(2'd3, 0, 1, 2, 3, 100, 1));
    send_item(make_item(MODE_POSE, 0, 0, 0, 0, 0, 1));
  endtask

  task automatic test_random(int count);
    int sent;
    int pick;
    int nb;
    int j;
    in_item_t it;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        nb = $urandom_range(1, 6);
        for (int b = 0; b < nb; b++) begin
          j = ($urandom_range(19) == 0) ? $urandom_range(24, 31) : $urandom_range(JOINTS - 1);
          send_item(make_item(MODE_POSE, j, rand_coord(), rand_coord(), rand_coord(),
                              ($urandom_range(4) == 0) ? $urandom_range(65535)
                                                       : $urandom_range(32768), b == nb - 1));
        end
        sent += nb;
      end else if (pick < 80) begin
        j = ($urandom_range(19) == 0) ? $urandom_range(24, 31) : $urandom_range(JOINTS - 1);
        send_item(make_item(MODE_BIND, j, rand_coord(), rand_coord(), rand_coord(), 0, 0));
        sent++;
      end else if (pick < 92) begin
        send_item(load_item($urandom_range(31), $urandom_range(15), $urandom_range(65535)));
        sent++;
      end else begin
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
        send_item(it);
        sent++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 3; i++) pos_acc[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 9;
    recv_stall_pct = 54;
    test_table_load();
    test_directed();
    test_random(547);
    send_idle_pct = 54;
    recv_stall_pct = 9;
    test_random(547);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(547);
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[linear_blend_skinning_core.f]
sv/lbs_pkg.sv
sv/lbs_datapath.sv
sv/lbs_controller.sv
sv/linear_blend_skinning_core.sv
sv/lbs_checker.sv
tb/linear_blend_skinning_core_tb.sv
